### design/box_downsample_2x2_defines.svh
// assertion macros used by the port checker of the 2x2 box downsampler
// expects clk and rst_n to be visible where a macro is used
`ifndef BOX_DOWNSAMPLE_2X2_DEFINES_SVH
`define BOX_DOWNSAMPLE_2X2_DEFINES_SVH

// consequent must hold in the same cycle
`define BDS_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define BDS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bds_pkg.sv
// shared types and constants of the 2x2 box downsampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int IN_WIDTH_BITS  = 11;
    localparam int IN_HEIGHT_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IN_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IN_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REDUCE_MODE = 2'd2;

    localparam logic [IN_WIDTH_BITS-1:0]  IN_WIDTH_RESET  = 11'd1024;
    localparam logic [IN_HEIGHT_BITS-1:0] IN_HEIGHT_RESET = 16'd1024;

    typedef struct packed {
        logic       hold;
        logic       odd_col;
        logic       merge;
        logic [1:0] missing;
    } bds_ctl_t;

endpackage

`default_nettype wire

### design/box_downsample_2x2.sv
// 2x2 box downsampler top level: counters, row memory, output register
// depends on bds_pkg and bds_chan
//
// usage
//   cfg channel: cfg_index 0 in_width, 1 in_height, 2 reduce_mode; always ready;
//     width or height writes restart the frame at the next pixel
//   s channel: one RGB pixel per item in raster order, ok flags in s_tuser
//   m channel: one item per 2x2 block, emitted after the block's last pixel
//   throughput: one pixel per clock while m_tready stays high
//   a block's valid bit passes v1_reg, v2_reg and v3_reg into the output register
//   the even row's horizontal pair results live in a row memory of DEPTH
//   = 2**(CB-1) >= MAX_WIDTH/2 entries, at most one read or write per pixel,
//   read data registered beside the odd row's pair for the merge stage
//   m_tlast marks the last item of an output row, m_tuser[3] the frame end
//   when the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops until the output register is taken
//   reset returns the counters and the left-pixel hold to zero and the
//   registers to 1024 x 1024 mean mode; the row memory needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module box_downsample_2x2
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 24
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // red_in, green_in, blue_in, zero pad
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // red_ok, green_ok, blue_ok
    input  logic [2:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // red_out, green_out, blue_out, zero pad
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    // red_out_ok, green_out_ok, blue_out_ok, frame_end
    output logic [3:0]               m_tuser,
    // row_end
    output logic                     m_tlast
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CB    = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
    localparam int AW    = CB - 1;
    localparam int DEPTH = 2 ** AW;
    localparam int EW    = 2 * SB + 3;
    localparam int WW    = 3 * EW;

    logic [IN_WIDTH_BITS-1:0]  in_width_reg;
    logic [IN_HEIGHT_BITS-1:0] in_height_reg;
    logic                      mode_reg;
    logic                      cfg_wr;
    logic                      cfg_restart;

    logic [CB-1:0]             col_reg;
    logic [CB-1:0]             col_next;
    logic [IN_HEIGHT_BITS-1:0] row_reg;
    logic [IN_HEIGHT_BITS-1:0] row_next;
    logic [31:0]               eff_w;
    logic                      last_col;
    logic                      last_row;
    logic                      pair;
    logic                      emit;

    logic                      en;
    logic                      acc;
    bds_ctl_t                  ctl;

    logic [WW-1:0]             mem [DEPTH];
    logic [WW-1:0]             wdata;
    logic [WW-1:0]             rd_reg;
    logic [AW-1:0]             addr;
    logic                      mem_we;
    logic                      mem_re;

    logic                      v1_reg, v2_reg, v3_reg;
    logic                      re1_reg, re2_reg, re3_reg;
    logic                      fe1_reg, fe2_reg, fe3_reg;

    logic                      m_valid_reg;
    logic                      row_end_reg;
    logic                      frame_end_reg;
    logic signed [SB-1:0]      out_val_reg [3];
    logic [2:0]                out_ok_reg;

    logic signed [SB:0]        wr_sum [3];
    logic signed [SB-1:0]      wr_max [3];
    logic [1:0]                wr_cnt [3];
    logic signed [SB-1:0]      res    [3];
    logic [2:0]                res_ok;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_wr && (cfg_index == CFG_IN_WIDTH || cfg_index == CFG_IN_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg  <= IN_WIDTH_RESET;
            in_height_reg <= IN_HEIGHT_RESET;
            mode_reg      <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_IN_WIDTH:    in_width_reg  <= cfg_data[IN_WIDTH_BITS-1:0];
                CFG_IN_HEIGHT:   in_height_reg <= cfg_data[IN_HEIGHT_BITS-1:0];
                CFG_REDUCE_MODE: mode_reg      <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign acc      = s_tvalid && en;

    always_comb
    begin
        eff_w = 32'(in_width_reg);
        if (eff_w == 32'd0)
            eff_w = 32'd1;
        if (eff_w > 32'(MAX_WIDTH))
            eff_w = 32'(MAX_WIDTH);
        last_col = 32'(col_reg) == (eff_w - 32'd1);
        if (in_height_reg == '0)
            last_row = row_reg == '0;
        else
            last_row = row_reg == (in_height_reg - 1'b1);
        pair = col_reg[0] || last_col;
        emit = pair && (row_reg[0] || last_row);

        ctl.hold    = !pair;
        ctl.odd_col = col_reg[0];
        ctl.merge   = row_reg[0];
        case ({col_reg[0], row_reg[0]})
            2'b11:   ctl.missing = 2'd0;
            2'b10:   ctl.missing = 2'd2;
            2'b01:   ctl.missing = 2'd2;
            default: ctl.missing = 2'd3;
        endcase

        col_next = last_col ? '0 : col_reg + 1'b1;
        if (!last_col)
            row_next = row_reg;
        else if (last_row)
            row_next = '0;
        else
            row_next = row_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // row memory
    assign addr   = col_reg[CB-1:1];
    assign mem_we = acc && pair && !row_reg[0] && !last_row;
    assign mem_re = acc && row_reg[0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= wdata;
        if (mem_re)
            rd_reg <= mem[addr];
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        assign wdata[ch*EW +: EW] = {wr_cnt[ch], wr_max[ch], wr_sum[ch]};

        bds_chan #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_chan (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .acc       (acc),
            .ctl       (ctl),
            .mode      (mode_reg),
            .sample    (s_tdata[ch*SB +: SB]),
            .sample_ok (s_tuser[ch]),
            .wr_sum    (wr_sum[ch]),
            .wr_max    (wr_max[ch]),
            .wr_cnt    (wr_cnt[ch]),
            .rd_sum    (rd_reg[ch*EW +: SB+1]),
            .rd_max    (rd_reg[ch*EW+SB+1 +: SB]),
            .rd_cnt    (rd_reg[ch*EW+2*SB+1 +: 2]),
            .result    (res[ch]),
            .result_ok (res_ok[ch])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= acc && emit;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re1_reg       <= last_col;
            fe1_reg       <= last_col && last_row;
            re2_reg       <= re1_reg;
            fe2_reg       <= fe1_reg;
            re3_reg       <= re2_reg;
            fe3_reg       <= fe2_reg;
            row_end_reg   <= re3_reg;
            frame_end_reg <= fe3_reg;
            out_val_reg   <= res;
            out_ok_reg    <= res_ok;
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int ch = 0; ch < 3; ch++)
            m_tdata[ch*SB +: SB] = out_val_reg[ch];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {frame_end_reg, out_ok_reg};
    assign m_tlast  = row_end_reg;

endmodule

`default_nettype wire

### design/bds_chan.sv
// one color channel: horizontal pairing, merge with the stored row, mean or max
// depends on bds_pkg
`timescale 1ns / 1ps
`default_nettype none

module bds_chan
    import bds_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          acc,
    input  bds_ctl_t                      ctl,
    input  logic                          mode,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          sample_ok,
    output logic signed [SAMPLE_BITS:0]   wr_sum,
    output logic signed [SAMPLE_BITS-1:0] wr_max,
    output logic [1:0]                    wr_cnt,
    input  logic signed [SAMPLE_BITS:0]   rd_sum,
    input  logic signed [SAMPLE_BITS-1:0] rd_max,
    input  logic [1:0]                    rd_cnt,
    output logic signed [SAMPLE_BITS-1:0] result,
    output logic                          result_ok
);

    localparam int SB    = SAMPLE_BITS;
    localparam int XB    = SB + 2;
    localparam int K     = XB + 2;
    localparam logic [K-1:0] RECIP = K'({K{1'b1}} / 3);

    logic signed [SB-1:0] left_val_reg;
    logic                 left_ok_reg;
    logic                 use_left;

    logic signed [SB:0]   p_sum_reg;
    logic signed [SB-1:0] p_max_reg;
    logic [1:0]           p_cnt_reg;
    logic                 merge_reg;
    logic [1:0]           miss_reg;

    logic                 use_rd;
    logic                 has_p;
    logic [XB-1:0]        m_sum;
    logic [2:0]           m_cnt;
    logic signed [SB-1:0] m_max;
    logic                 m_any;
    logic signed [SB-1:0] f_max;
    logic [2:0]           f_cnt;

    logic [XB-1:0]        s_sum_reg;
    logic signed [SB-1:0] s_max_reg;
    logic [2:0]           s_cnt_reg;

    logic                 neg;
    logic [XB-1:0]        mag;
    logic [XB-1:0]        bias;
    logic [XB-1:0]        x_val;
    logic [XB+K-1:0]      prod;

    logic [XB-1:0]        x_reg;
    logic [XB-1:0]        q0_reg;
    logic                 neg_reg;
    logic [2:0]           cnt_reg;
    logic signed [SB-1:0] max_reg;

    logic [XB+1:0]        rem;
    logic [XB-1:0]        q3;
    logic [XB-1:0]        quo;
    logic [XB-1:0]        res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_val_reg <= '0;
            left_ok_reg  <= 1'b0;
        end
        else if (acc)
        begin
            if (ctl.hold)
            begin
                left_val_reg <= sample;
                left_ok_reg  <= sample_ok;
            end
            else
            begin
                left_val_reg <= '0;
                left_ok_reg  <= 1'b0;
            end
        end
    end

    // horizontal pair
    always_comb
    begin
        use_left = ctl.odd_col && left_ok_reg;
        wr_sum   = (use_left ? {left_val_reg[SB-1], left_val_reg} : '0)
                 + (sample_ok ? {sample[SB-1], sample} : '0);
        wr_cnt   = {1'b0, use_left} + {1'b0, sample_ok};
        wr_max   = (use_left && (!sample_ok || left_val_reg > sample)) ? left_val_reg : sample;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sum_reg <= wr_sum;
            p_max_reg <= wr_max;
            p_cnt_reg <= wr_cnt;
            merge_reg <= ctl.merge;
            miss_reg  <= ctl.missing;
        end
    end

    // merge with the even row and fill missing edge positions with zero
    always_comb
    begin
        use_rd = merge_reg && (rd_cnt != 2'd0);
        has_p  = p_cnt_reg != 2'd0;
        m_sum  = {p_sum_reg[SB], p_sum_reg}
               + (use_rd ? {rd_sum[SB], rd_sum} : {XB{1'b0}});
        m_cnt  = {1'b0, p_cnt_reg} + (use_rd ? {1'b0, rd_cnt} : 3'd0);
        m_max  = (use_rd && (!has_p || rd_max > p_max_reg)) ? rd_max : p_max_reg;
        m_any  = has_p || use_rd;
        if (miss_reg != 2'd0)
            f_max = (m_any && !m_max[SB-1]) ? m_max : '0;
        else
            f_max = m_max;
        f_cnt  = m_cnt + {1'b0, miss_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_sum_reg <= m_sum;
            s_max_reg <= f_max;
            s_cnt_reg <= f_cnt;
        end
    end

    // magnitude, rounding bias and reciprocal of three
    always_comb
    begin
        neg = s_sum_reg[XB-1];
        mag = neg ? (~s_sum_reg + 1'b1) : s_sum_reg;
        case (s_cnt_reg)
            3'd2, 3'd3: bias = XB'(1);
            3'd4:       bias = XB'(2);
            default:    bias = '0;
        endcase
        x_val = mag + bias;
        prod  = (XB+K)'(x_val) * (XB+K)'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_val;
            q0_reg  <= prod[XB+K-1:K];
            neg_reg <= neg;
            cnt_reg <= s_cnt_reg;
            max_reg <= s_max_reg;
        end
    end

    always_comb
    begin
        rem = {2'b00, x_reg} - ({2'b00, q0_reg} + {1'b0, q0_reg, 1'b0});
        q3  = q0_reg + ((rem >= (XB+2)'(3)) ? XB'(1) : XB'(0));
        case (cnt_reg)
            3'd2:    quo = x_reg >> 1;
            3'd3:    quo = q3;
            3'd4:    quo = x_reg >> 2;
            default: quo = x_reg;
        endcase
        res_full  = neg_reg ? (~quo + 1'b1) : quo;
        result_ok = cnt_reg != 3'd0;
        if (!result_ok)
            result = '0;
        else if (mode)
            result = max_reg;
        else
            result = res_full[SB-1:0];
    end

endmodule

`default_nettype wire

### design/bds_checker.sv
// port-level checks of the 2x2 box downsampler, bound to the top level
// depends on box_downsample_2x2_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "box_downsample_2x2_defines.svh"

module bds_checker #(
    parameter int SAMPLE_BITS = 24
)(
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  s_tready,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    input wire logic [3:0]                            m_tuser,
    input wire logic                                  m_tlast
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = ((3*SB+7)/8)*8;

    logic          m_stall;
    logic [DW+4:0] m_item;
    logic [2:0]    zero_ok;

    assign m_stall    = m_tvalid && !m_tready;
    assign m_item     = {m_tlast, m_tuser, m_tdata};
    assign zero_ok[0] = m_tuser[0] || m_tdata[SB-1:0] == '0;
    assign zero_ok[1] = m_tuser[1] || m_tdata[2*SB-1:SB] == '0;
    assign zero_ok[2] = m_tuser[2] || m_tdata[3*SB-1:2*SB] == '0;

    `BDS_CHECK_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_item), "stalled item changed")
    `BDS_CHECK_NOW(a_frame_row, m_tvalid && m_tuser[3], m_tlast, "frame end without row end")
    `BDS_CHECK_NOW(a_nan_zero, m_tvalid, &zero_ok, "invalid channel with nonzero sample")
    `BDS_CHECK_NOW(a_ready_empty, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind box_downsample_2x2 bds_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### verif/box_downsample_2x2_checker.sv
// checker for the 2x2 box downsampler: follows register writes and accepted pixels,
// predicts each reduced block and compares it field by field with the output stream
// depends on bds_pkg
`timescale 1ns / 1ps

module box_downsample_2x2_checker
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 24
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic [2:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  logic [3:0]                        m_tuser,
    input  logic                              m_tlast,
    output int                                mismatches,
    output int                                pending,
    output int                                blocks_seen
);

    localparam int SB         = SAMPLE_BITS;
    localparam int DW         = ((3*SB+7)/8)*8;
    localparam int STORE_COLS = MAX_WIDTH / 2 + 1;

    typedef struct {
        longint      sum;
        longint      peak;
        int unsigned cnt;
        bit          any;
    } tally_t;

    typedef struct packed {
        logic [DW-1:0] samples;
        logic [2:0]    oks;
        logic          row_end;
        logic          frame_end;
    } block_t;

    logic [IN_WIDTH_BITS-1:0]  width_reg;
    logic [IN_HEIGHT_BITS-1:0] height_reg;
    logic                      mode_max;
    tally_t                    row_pairs [STORE_COLS*3];
    longint                    left_val [3];
    bit                        left_ok [3];
    int unsigned               col_pos;
    int unsigned               row_pos;
    block_t                    blocks_due [$];
    block_t                    want;
    block_t                    got;
    int                        k;

    function automatic tally_t tally_add(input tally_t t, input longint v, input bit ok);
        tally_t n;
        n = t;
        if (ok)
        begin
            n.sum += v;
            n.cnt += 1;
            if (!n.any || v > n.peak)
                n.peak = v;
            n.any = 1'b1;
        end
        return n;
    endfunction

    function automatic tally_t tally_merge(input tally_t t, input tally_t u);
        tally_t n;
        n = t;
        if (u.any)
        begin
            n.sum += u.sum;
            n.cnt += u.cnt;
            if (!n.any || u.peak > n.peak)
                n.peak = u.peak;
            n.any = 1'b1;
        end
        return n;
    endfunction

    // ties away from zero
    function automatic longint mean_round(input longint s, input int unsigned c);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = (2 * mag + longint'(c)) / (2 * longint'(c));
        return (s < 0) ? -q : q;
    endfunction

    task report(input string msg);
        if (mismatches < 100)
            $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task reduce_pixel(input logic [DW-1:0] d, input logic [2:0] okv);
        int unsigned w;
        int unsigned h;
        int unsigned ocol;
        int unsigned full;
        int unsigned missing;
        int          ch;
        bit          last_col;
        bit          last_row;
        bit          odd_col;
        bit          odd_row;
        bit          made;
        longint      v;
        longint      r;
        tally_t      pair;
        block_t      blk;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        last_col = (col_pos + 1 == w);
        last_row = (row_pos + 1 == h);
        odd_col  = col_pos[0];
        odd_row  = row_pos[0];
        ocol     = (col_pos >> 1) % STORE_COLS;
        made     = 1'b0;
        blk      = '0;
        for (ch = 0; ch < 3; ch++)
        begin
            v = $signed(d[ch*SB +: SB]);
            if (!odd_col && !last_col)
            begin
                left_val[ch] = v;
                left_ok[ch]  = okv[ch];
            end
            else
            begin
                pair = '{0, 0, 0, 1'b0};
                if (odd_col)
                    pair = tally_add(pair, left_val[ch], left_ok[ch]);
                pair = tally_add(pair, v, okv[ch]);
                left_val[ch] = 0;
                left_ok[ch]  = 1'b0;
                if (!odd_row && !last_row)
                    row_pairs[ocol*3 + ch] = pair;
                else
                begin
                    if (odd_row)
                        pair = tally_merge(pair, row_pairs[ocol*3 + ch]);
                    full    = (odd_col ? 2 : 1) * (odd_row ? 2 : 1);
                    missing = 4 - full;
                    // positions past the right or bottom edge count as valid zeros
                    if (missing > 0)
                        pair = tally_add(pair, 0, 1'b1);
                    if (missing > 1)
                        pair.cnt += missing - 1;
                    if (pair.any)
                    begin
                        r = mode_max ? pair.peak : mean_round(pair.sum, pair.cnt);
                        blk.samples[ch*SB +: SB] = r[SB-1:0];
                        blk.oks[ch] = 1'b1;
                    end
                    made = 1'b1;
                end
            end
        end
        if (made)
        begin
            blk.row_end   = last_col;
            blk.frame_end = last_col && last_row;
            blocks_due.push_back(blk);
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = IN_WIDTH_RESET;
            height_reg = IN_HEIGHT_RESET;
            mode_max   = 1'b0;
            col_pos    = 0;
            row_pos    = 0;
            for (k = 0; k < 3; k++)
            begin
                left_val[k] = 0;
                left_ok[k]  = 1'b0;
            end
            for (k = 0; k < STORE_COLS*3; k++)
                row_pairs[k] = '{0, 0, 0, 1'b0};
            blocks_due.delete();
            mismatches  = 0;
            blocks_seen = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IN_WIDTH:
                    begin
                        width_reg = cfg_data[IN_WIDTH_BITS-1:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    CFG_IN_HEIGHT:
                    begin
                        height_reg = cfg_data[IN_HEIGHT_BITS-1:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    CFG_REDUCE_MODE:
                        mode_max = cfg_data[0];
                    default:
                        ;
                endcase
            end
            if (s_tvalid && s_tready)
                reduce_pixel(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
            begin
                blocks_seen++;
                got.samples   = m_tdata;
                got.oks       = m_tuser[2:0];
                got.frame_end = m_tuser[3];
                got.row_end   = m_tlast;
                if (blocks_due.size() == 0)
                    report($sformatf("block %0d arrived with none due", blocks_seen));
                else
                begin
                    want = blocks_due.pop_front();
                    for (k = 0; k < 3; k++)
                    begin
                        if (got.samples[k*SB +: SB] !== want.samples[k*SB +: SB])
                            report($sformatf("block %0d channel %0d sample %h, expected %h",
                                blocks_seen, k, got.samples[k*SB +: SB],
                                want.samples[k*SB +: SB]));
                        if (got.oks[k] !== want.oks[k])
                            report($sformatf("block %0d channel %0d ok %b, expected %b",
                                blocks_seen, k, got.oks[k], want.oks[k]));
                    end
                    if (got.row_end !== want.row_end)
                        report($sformatf("block %0d row end %b, expected %b",
                            blocks_seen, got.row_end, want.row_end));
                    if (got.frame_end !== want.frame_end)
                        report($sformatf("block %0d frame end %b, expected %b",
                            blocks_seen, got.frame_end, want.frame_end));
                end
            end
            pending = blocks_due.size();
        end
    end

endmodule

### verif/tb_box_downsample_2x2.sv
// testbench top of the 2x2 box downsampler: clock, reset, register writes,
// pixel stimulus with random idling and receiver stalls, watchdog and verdict
// depends on bds_pkg, box_downsample_2x2 and box_downsample_2x2_checker
`timescale 1ns / 1ps

module tb_box_downsample_2x2;
    import bds_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int SB            = 24;
    localparam int DW            = ((3*SB+7)/8)*8;
    localparam int RANDOM_PIXELS = 150;
    localparam int CALM_PIXELS   = 60;
    localparam int HOLD_OFF      = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN         = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [DW-1:0]            s_tdata   = '0;
    logic [2:0]               s_tuser   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [DW-1:0]            m_tdata;
    logic [3:0]               m_tuser;
    logic                     m_tlast;

    logic s_took   = 1'b0;
    logic m_took   = 1'b0;
    logic cfg_took = 1'b0;
    bit   calm     = 1'b0;
    bit   squeeze  = 1'b0;
    int   pixels_sent   = 0;
    int   random_pixels = 0;
    int   mismatches;
    int   pending;
    int   blocks_seen;

    box_downsample_2x2 #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    box_downsample_2x2_checker #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SB)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .pending     (pending),
        .blocks_seen (blocks_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        s_took   <= s_tvalid && s_tready;
        m_took   <= m_tvalid && m_tready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SB-1){1'b1}}};
            1:       return {1'b1, {(SB-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            4, 5:    return SB'(int'($urandom_range(0, 31)) - 16);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] pick_oks();
        case ($urandom_range(0, 9))
            0:       return 3'b000;
            1, 2, 3: return 3'($urandom);
            default: return 3'b111;
        endcase
    endfunction

    // data is {blue, green, red}, oks is {blue, green, red}
    task automatic send_pixel(input logic [DW-1:0] d, input logic [2:0] okv);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= okv;
        do @(negedge clk); while (!s_took);
        pixels_sent++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(DW'({pick_sample(), pick_sample(), pick_sample()}), pick_oks());
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_took);
    endtask

    task automatic program_frame(input logic [15:0] wdata, input logic [15:0] hdata,
                                 input bit mode);
        write_reg(CFG_IN_WIDTH, wdata);
        write_reg(CFG_IN_HEIGHT, hdata);
        write_reg(CFG_REDUCE_MODE, {15'($urandom), mode});
        cfg_valid <= 1'b0;
    endtask

    task automatic program_mode(input bit mode);
        write_reg(CFG_REDUCE_MODE, {15'($urandom), mode});
        cfg_valid <= 1'b0;
    endtask

    // wait until every due block is out and the pipeline has emptied
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN) @(negedge clk);
    endtask

    initial
    begin : receiver
        int n;
        bit hold;
        bit squeezed;
        squeezed = 1'b0;
        do @(negedge clk); while (!rst_n);
        forever
        begin
            if (squeeze && !squeezed)
            begin
                hold     = 1'b1;
                n        = HOLD_OFF;
                squeezed = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                hold = 1'b1;
                n    = $urandom_range(1, 7);
            end
            else
            begin
                hold = 1'b0;
                n    = calm ? 1 : $urandom_range(1, 24);
            end
            m_tready <= !hold;
            repeat (n) @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if (s_took || m_took || cfg_took)
                quiet = 0;
            else
                quiet++;
        end
        $display("no traffic for %0d cycles, %0d blocks still due", STALL_LIMIT, pending);
        $display("[box_downsample_2x2] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int          w;
        int          h;
        int          weff;
        int          rows;
        int          total;
        int          i;
        logic [15:0] wdata;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 3x3 mean: right, bottom and corner blocks, extremes, invalid samples
        program_frame(16'd3, 16'd3, 1'b0);
        send_pixel({24'h000001, 24'h800000, 24'h7FFFFF}, 3'b111);
        send_pixel({24'h000002, 24'h800000, 24'h7FFFFF}, 3'b011);
        send_pixel({24'h000100, 24'hFFFFFF, 24'h123456}, 3'b101);
        send_pixel({24'h000003, 24'h800000, 24'h7FFFFF}, 3'b110);
        send_pixel({24'h000000, 24'h800000, 24'h7FFFFF}, 3'b000);
        send_pixel({24'hFFFF00, 24'h7FFFFF, 24'h800000}, 3'b111);
        send_pixel({24'h7FFFFF, 24'hFFFF80, 24'h000080}, 3'b111);
        send_pixel({24'h800000, 24'h000181, 24'hFFFF7F}, 3'b010);
        send_pixel({24'h555555, 24'h7FFFFE, 24'h800001}, 3'b000);
        settle();

        // 2x2 max over negative extremes
        program_frame(16'd2, 16'd2, 1'b1);
        send_pixel({24'h800000, 24'h800000, 24'h800000}, 3'b111);
        send_pixel({24'h800001, 24'h800000, 24'h7FFFFF}, 3'b110);
        send_pixel({24'h7FFFFF, 24'h000000, 24'hFFFFFF}, 3'b001);
        send_pixel({24'h000000, 24'h000000, 24'h000000}, 3'b000);
        settle();

        // 4x2 mean: rounding ties both signs, a channel with no valid sample
        program_frame(16'd4, 16'd2, 1'b0);
        send_pixel({24'h000005, 24'h000002, 24'h000001}, 3'b011);
        send_pixel({24'h000007, 24'h000000, 24'h000000}, 3'b011);
        send_pixel({24'hFFFFFF, 24'h000001, 24'hFFFFFE}, 3'b111);
        send_pixel({24'hFFFFFE, 24'h000002, 24'h000000}, 3'b111);
        send_pixel({24'h000000, 24'h000000, 24'h000000}, 3'b011);
        send_pixel({24'h000000, 24'h000000, 24'h000000}, 3'b011);
        send_pixel({24'h000000, 24'h000000, 24'h000000}, 3'b001);
        send_pixel({24'h000000, 24'h000000, 24'h000000}, 3'b001);
        settle();

        // zero width and height act as one, unused index ignored, mode-only write
        write_reg(CFG_UNUSED, 16'hFFFF);
        program_frame(16'd0, 16'd0, 1'b1);
        send_pixel({24'h800000, 24'hFFFF00, 24'h7FFFFF}, 3'b110);
        settle();
        program_mode(1'b0);
        send_pixel({24'h000004, 24'hFFFFFC, 24'h000003}, 3'b111);
        settle();

        // oversize width saturates to the widest line
        program_frame(16'd2047, 16'd1, 1'b0);
        send_random(MAX_WIDTH);
        settle();

        // tallest frame, only its first rows
        program_frame(16'd2, 16'd65535, 1'b1);
        send_random(12);
        settle();

        // long receiver hold-off while pixels keep coming
        squeeze = 1'b1;
        program_frame(16'd8, 16'd6, 1'b0);
        send_random(48);
        random_pixels = 48;

        while (random_pixels < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 19))
                0:       w = $urandom_range(13, 120);
                1:       w = 0;
                default: w = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 19))
                0:       h = 0;
                1:       h = 65535;
                default: h = $urandom_range(1, 6);
            endcase
            weff = (w == 0) ? 1 : w;
            rows = (h == 0) ? 1 : (h > 6) ? $urandom_range(1, 7) : h;
            if (w > 12 && rows > 2)
                rows = 2;
            total = weff * rows;
            // some frames are cut short by the next geometry write
            if ($urandom_range(0, 7) == 0)
                total = $urandom_range(1, total);
            wdata = 16'(w);
            if ($urandom_range(0, 9) == 0)
                wdata[15:11] = 5'($urandom_range(1, 31));
            settle();
            program_frame(wdata, 16'(h), 1'($urandom_range(0, 1)));
            for (i = 0; i < total; i++)
            begin
                if (i > 0 && i % weff == 0 && $urandom_range(0, 15) == 0)
                begin
                    settle();
                    program_mode(1'($urandom_range(0, 1)));
                end
                send_random(1);
            end
            random_pixels += total;
            if (random_pixels >= RANDOM_PIXELS - CALM_PIXELS)
                calm = 1'b1;
        end

        settle();
        $display("sent %0d pixels (%0d random) and checked %0d blocks, %0d mismatches",
            pixels_sent, random_pixels, blocks_seen, mismatches);
        $display("covered mean and max, odd edges, empty channels, widths 1 to 1024, stalls");
        if (mismatches == 0)
            $display("[box_downsample_2x2] OK");
        else
            $display("[box_downsample_2x2] ERROR");
        $finish;
    end

endmodule
